// ===== rtl/mrrc_pkg.sv =====
package mrrc_pkg;

    localparam logic [15:0] CrcInit  = 16'hFFFF;
    localparam logic [15:0] CrcPoly  = 16'hA001;
    localparam logic [7:0]  BadCount = 8'd252;
    localparam logic [7:0]  ExpectedCountReset = 8'd2;

    typedef enum logic
    {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } result_kind_t;

    typedef enum logic [1:0]
    {
        STATUS_OK        = 2'd0,
        STATUS_CRC_ERR   = 2'd1,
        STATUS_COUNT_ERR = 2'd2
    } frame_status_t;

    typedef struct packed
    {
        result_kind_t  kind;
        logic [15:0]   word;
        frame_status_t status;
        logic          last;
    } result_t;

    // One byte of the reflected CRC-16 update, one bit per step.
    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CrcPoly;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/mrrc_frame_engine.sv =====
module mrrc_frame_engine
    import mrrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  rx_byte,
    input  logic        frame_start,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    output logic        res_push,
    output result_t     res
);

    logic [8:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  held_reg, held_next;
    logic [7:0]  low_reg, low_next;
    logic [7:0]  expected_reg;
    logic [8:0]  data_end;
    logic [15:0] crc_upd;

    assign data_end = {1'b0, count_reg} + 9'd3;
    assign crc_upd  = crc_add(crc_reg, rx_byte);

    always_comb
    begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        count_next = count_reg;
        held_next  = held_reg;
        low_next   = low_reg;
        res_push   = 1'b0;
        res.kind   = KIND_DATA;
        res.word   = 16'h0000;
        res.status = STATUS_OK;
        res.last   = 1'b0;
        if (accept)
        begin
            priority if (frame_start)
            begin
                crc_next   = crc_add(CrcInit, rx_byte);
                count_next = 8'h00;
                held_next  = 8'h00;
                low_next   = 8'h00;
                pos_next   = 9'd1;
            end
            else if (pos_reg == 9'd0)
            begin
                // Bytes outside a frame are dropped.
            end
            else if (pos_reg < 9'd3)
            begin
                crc_next = crc_upd;
                if (pos_reg == 9'd2)
                begin
                    count_next = rx_byte;
                end
                pos_next = pos_reg + 9'd1;
            end
            else if (pos_reg < data_end)
            begin
                crc_next = crc_upd;
                pos_next = pos_reg + 9'd1;
                // An odd position holds the first byte of a pair.
                if (pos_reg[0])
                begin
                    held_next = rx_byte;
                end
                else
                begin
                    res_push = 1'b1;
                    res.word = {held_reg, rx_byte};
                end
            end
            else if (pos_reg == data_end)
            begin
                low_next = rx_byte;
                pos_next = pos_reg + 9'd1;
            end
            else
            begin
                res_push = 1'b1;
                res.kind = KIND_STATUS;
                res.last = 1'b1;
                priority if (count_reg == BadCount)
                begin
                    res.status = STATUS_CRC_ERR;
                end
                else if (low_reg != crc_reg[7:0] || rx_byte != crc_reg[15:8])
                begin
                    res.status = STATUS_CRC_ERR;
                end
                else if (count_reg != expected_reg)
                begin
                    res.status = STATUS_COUNT_ERR;
                end
                else
                begin
                    res.status = STATUS_OK;
                end
                pos_next = 9'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= 9'd0;
            crc_reg      <= CrcInit;
            count_reg    <= 8'h00;
            held_reg     <= 8'h00;
            low_reg      <= 8'h00;
            expected_reg <= ExpectedCountReset;
        end
        else
        begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            count_reg <= count_next;
            held_reg  <= held_next;
            low_reg   <= low_next;
            if (cfg_we)
            begin
                expected_reg <= cfg_data;
            end
        end
    end

endmodule

// ===== rtl/mrrc_out_queue.sv =====
module mrrc_out_queue
    import mrrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    res_valid,
    input  logic    res_stall,
    output result_t res_data
);

    result_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign res_valid = (count_reg != 2'd0);
    assign pop       = res_valid && !res_stall;
    assign res_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/modbus_read_response_checker_unit.sv =====
// Channel   Direction  Handshake            Payload
// rx        in         rx_valid / rx_stall  rx_byte, frame_start
// res       out        res_valid/res_stall  result_kind, data_word, frame_status, last
// cfg       in         cfg_we               cfg_data (expected data byte count)
//
// One received byte is taken per cycle while the queue has room; its result
// word, if any, is ready in the result queue on the next cycle.  The CRC update
// and frame tracking sit between the frame state registers and a two-entry queue.
// Reset clears the frame state, sets the expected count to 2 and empties the queue.
// rx_stall rises only when both queue entries are waiting, so a stalled
// consumer costs input throughput only after two words have piled up.
module modbus_read_response_checker_unit
    import mrrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    input  logic        frame_start,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        result_kind,
    output logic [15:0] data_word,
    output logic [1:0]  frame_status,
    output logic        last
);

    logic    accept;
    logic    push;
    logic    full;
    result_t push_data;
    result_t head;

    // A byte is accepted whenever the queue has room for its possible word.
    assign rx_stall = full;
    assign accept   = rx_valid && !full;

    // Frame tracking, CRC and status decision.
    mrrc_frame_engine u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .res_push    (push),
        .res         (push_data)
    );

    // Output register with one skid entry behind it.
    mrrc_out_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (head)
    );

    assign result_kind  = head.kind;
    assign data_word    = head.word;
    assign frame_status = head.status;
    assign last         = head.last;

`ifndef ASSERT_OFF
    // The input can only be held off while results are waiting.
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> res_valid)
        else $error("rx_stall without a waiting result");

    // Status words carry last, data words never do.
    a_last_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (last == result_kind))
        else $error("last does not match result_kind");

    // A status word has no data and a legal status code.
    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && result_kind) |-> (data_word == 16'h0000 &&
            (frame_status == STATUS_OK || frame_status == STATUS_CRC_ERR ||
             frame_status == STATUS_COUNT_ERR)))
        else $error("malformed status word");

    // A data word carries an ok status field.
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !result_kind) |-> (frame_status == STATUS_OK))
        else $error("data word with nonzero status");
`endif

endmodule
